/* rtl/core/sdtl_pkg.sv */
// Package for the servo dead-time / first-order-lag block: types, constants, microcode.
`default_nettype none
package sdtl_pkg;

  localparam int unsigned DelayDepthDef = 64;
  localparam int unsigned ValW  = 32;
  localparam int unsigned LagW  = 25;
  localparam int unsigned DeadW = 7;
  localparam int unsigned AccW  = 128;
  localparam int unsigned ProdW = 65;
  localparam int unsigned StepW = 4;

  localparam logic [LagW-1:0]  LagOne     = 25'h100_0000;
  localparam logic [ValW-1:0]  ValMax     = 32'h7FFF_FFFF;
  localparam logic [ValW-1:0]  ValMin     = 32'h8000_0000;
  localparam logic [ValW-1:0]  CoefOne    = 32'h0100_0000;
  localparam logic [DeadW-1:0] DeadRst    = 7'd1;

  localparam logic [StepW-1:0] StepLoop   = 4'd0;
  localparam logic [StepW-1:0] StepFetch  = 4'd9;
  localparam logic [StepW-1:0] StepFinish = 4'd11;

  typedef enum logic [2:0] {
    REG_C0, REG_C1, REG_C2, REG_C3, REG_LAG, REG_DEAD, REG_STEER
  } reg_idx_e;

  typedef struct packed {
    logic signed [ValW-1:0] set_value;
    logic signed [ValW-1:0] measured_angle;
    logic                   use_measured;
  } in_beat_t;

  typedef struct packed {
    logic signed [ValW-1:0] predicted_angle;
    logic                   line_filled;
  } out_beat_t;

  typedef enum logic [2:0] {MUL_NONE, MUL_C3, MUL_H0, MUL_H1, MUL_H2} mul_src_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SAVE} acc_op_e;
  typedef enum logic [1:0] {LD_C2, LD_C1, LD_CV} load_sel_e;
  typedef enum logic [2:0] {ACT_NEXT, ACT_DECIDE, ACT_FETCH, ACT_LAG, ACT_FINISH} act_e;

  typedef struct packed {
    mul_src_e   mul_src;
    logic       top_signed;
    acc_op_e    acc_op;
    load_sel_e  ld_sel;
    logic [1:0] shift;
    act_e       act;
  } uword_t;

  typedef struct packed {
    logic push;
    logic shrink;
  } dl_ctrl_t;

  typedef struct packed {
    logic filled;
    logic bypass;
  } dl_stat_t;

  // one bit of the root search takes steps 0..8, then the delay and lag steps
  function automatic uword_t ucode(input logic [StepW-1:0] s);
    uword_t w;
    unique case (s)
      4'd0:    w = '{MUL_C3,   1'b1, ACC_LOAD, LD_C2, 2'd0, ACT_NEXT};
      4'd1:    w = '{MUL_NONE, 1'b0, ACC_SAVE, LD_C1, 2'd0, ACT_NEXT};
      4'd2:    w = '{MUL_H0,   1'b0, ACC_HOLD, LD_C2, 2'd0, ACT_NEXT};
      4'd3:    w = '{MUL_H1,   1'b1, ACC_ADD,  LD_C2, 2'd0, ACT_NEXT};
      4'd4:    w = '{MUL_NONE, 1'b0, ACC_SAVE, LD_CV, 2'd1, ACT_NEXT};
      4'd5:    w = '{MUL_H0,   1'b0, ACC_HOLD, LD_C2, 2'd0, ACT_NEXT};
      4'd6:    w = '{MUL_H1,   1'b0, ACC_ADD,  LD_C2, 2'd0, ACT_NEXT};
      4'd7:    w = '{MUL_H2,   1'b1, ACC_ADD,  LD_C2, 2'd1, ACT_NEXT};
      4'd8:    w = '{MUL_NONE, 1'b0, ACC_HOLD, LD_C2, 2'd2, ACT_DECIDE};
      4'd9:    w = '{MUL_NONE, 1'b0, ACC_HOLD, LD_C2, 2'd0, ACT_FETCH};
      4'd10:   w = '{MUL_NONE, 1'b0, ACC_HOLD, LD_C2, 2'd0, ACT_LAG};
      4'd11:   w = '{MUL_NONE, 1'b0, ACC_HOLD, LD_C2, 2'd0, ACT_FINISH};
      default: w = '{MUL_NONE, 1'b0, ACC_HOLD, LD_C2, 2'd0, ACT_NEXT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/sdtl_delay_line.sv */
// Dead-time delay line: ring memory with head pointer and fill count.
`default_nettype none
module sdtl_delay_line #(
  parameter int unsigned DEPTH = sdtl_pkg::DelayDepthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sdtl_pkg::dl_ctrl_t              ctrl_i,
  input  wire logic [sdtl_pkg::ValW-1:0]       wr_data_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]      eff_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]      eff_new_i,
  output logic      [sdtl_pkg::ValW-1:0]       rd_data_o,
  output sdtl_pkg::dl_stat_t                   stat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned SW = CW + 1;

  logic [sdtl_pkg::ValW-1:0] mem_q [DEPTH];
  logic [sdtl_pkg::ValW-1:0] rd_q;
  logic [AW-1:0] head_q, head_d, wr_addr, head_inc, head_drop;
  logic [CW-1:0] fill_q, fill_d, fill_inc, drop, diff;
  logic [SW-1:0] wr_sum, drop_sum;

  always_comb begin
    wr_sum   = SW'(head_q) + SW'(fill_q);
    wr_addr  = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : AW'(wr_sum);
    fill_inc = fill_q + CW'(1);
    head_inc = (head_q == AW'(DEPTH-1)) ? '0 : head_q + AW'(1);
    diff     = eff_i - eff_new_i;
    drop     = (diff > fill_q) ? fill_q : diff;
    drop_sum = SW'(head_q) + SW'(drop);
    head_drop = (drop_sum >= SW'(DEPTH)) ? AW'(drop_sum - SW'(DEPTH)) : AW'(drop_sum);
    stat_o.filled = (fill_inc >= eff_i);
    stat_o.bypass = (fill_q == '0);
    head_d = head_q;
    fill_d = fill_q;
    if (ctrl_i.push) begin
      if (stat_o.filled) begin
        head_d = head_inc;
      end else begin
        fill_d = fill_inc;
      end
    end else if (ctrl_i.shrink && (eff_i > eff_new_i)) begin
      head_d = head_drop;
      fill_d = fill_q - drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    rd_q <= mem_q[head_q];
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

/* rtl/core/servo_dead_time_first_order_lag_top.sv */
// Servo model top level: cubic inversion sequencer, dead time, first-order lag, APB registers.
// Sequence when steerable: 32 search bits of 9 steps each, then fetch, lag multiply, finish;
//   with a zero cubic term only fetch, lag multiply, finish; when not steerable only finish.
// One beat at a time: the next beat is taken the cycle after the result is registered; the
//   search takes 9 steps per bit on the shared 33x32 multiplier.
// Reset: registers take their defaults, delay line empty, no prediction; no clearing pass.
`default_nettype none
module servo_dead_time_first_order_lag_top #(
  parameter int unsigned DELAY_DEPTH = sdtl_pkg::DelayDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sdtl_pkg::in_beat_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sdtl_pkg::out_beat_t       out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned CW = $clog2(DELAY_DEPTH+1);
  localparam int unsigned EW = (CW > sdtl_pkg::DeadW) ? CW : sdtl_pkg::DeadW;

  function automatic logic [CW-1:0] eff_dead(input logic [sdtl_pkg::DeadW-1:0] d);
    logic [EW-1:0] dx;
    dx = EW'(d);
    if (d == '0) return CW'(1);
    if (dx > EW'(DELAY_DEPTH)) return CW'(DELAY_DEPTH);
    return CW'(dx);
  endfunction

  logic signed [31:0] c0_q, c1_q, c2_q, c3_q;
  logic [sdtl_pkg::LagW-1:0]  lag_q;
  logic [sdtl_pkg::DeadW-1:0] dead_q;
  logic steer_q;

  logic busy_q, pass_q, out_valid_q, pv_q;
  logic [sdtl_pkg::StepW-1:0] step_q;
  logic [4:0] bit_q;
  logic [31:0] r_q;
  logic signed [31:0] x_q, sv_q, meas_q, tgt_q, cur_q, last_q;
  logic usem_q, filled_q, byp_q;
  logic signed [64:0] prod_q;
  logic signed [127:0] acc_q, h_q;
  logic signed [58:0] lagp_q;
  sdtl_pkg::out_beat_t out_q;

  sdtl_pkg::uword_t uw;
  sdtl_pkg::reg_idx_e idx;
  sdtl_pkg::dl_ctrl_t dl_ctrl;
  sdtl_pkg::dl_stat_t dl_stat;
  logic [31:0] rd_data;
  logic cfg_we, in_fire, fin_fire, ok;
  logic signed [32:0] mul_a, cv, diff;
  logic signed [64:0] mul_full;
  logic signed [127:0] prod_sh, add_res, ld_val;
  logic [31:0] r_new, bit_mask, next_mask;
  logic [4:0] bit_dec;
  logic signed [31:0] cur_sel, delayed;
  logic [sdtl_pkg::LagW-1:0] lag_eff;
  logic signed [25:0] lag_s;
  logic signed [58:0] lag_full;
  logic signed [34:0] quot;
  logic signed [35:0] sum;
  logic signed [31:0] next_val;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign idx     = sdtl_pkg::reg_idx_e'(paddr[4:2]);
  assign in_stall_o = busy_q;
  assign in_fire = in_valid_i & ~busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    unique case (idx)
      sdtl_pkg::REG_C0:    prdata = c0_q;
      sdtl_pkg::REG_C1:    prdata = c1_q;
      sdtl_pkg::REG_C2:    prdata = c2_q;
      sdtl_pkg::REG_C3:    prdata = c3_q;
      sdtl_pkg::REG_LAG:   prdata = 32'(lag_q);
      sdtl_pkg::REG_DEAD:  prdata = 32'(dead_q);
      sdtl_pkg::REG_STEER: prdata = 32'(steer_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q    <= '0;
      c1_q    <= sdtl_pkg::CoefOne;
      c2_q    <= '0;
      c3_q    <= sdtl_pkg::CoefOne;
      lag_q   <= sdtl_pkg::LagOne;
      dead_q  <= sdtl_pkg::DeadRst;
      steer_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (idx)
        sdtl_pkg::REG_C0:    c0_q    <= pwdata;
        sdtl_pkg::REG_C1:    c1_q    <= pwdata;
        sdtl_pkg::REG_C2:    c2_q    <= pwdata;
        sdtl_pkg::REG_C3:    c3_q    <= pwdata;
        sdtl_pkg::REG_LAG:   lag_q   <= pwdata[sdtl_pkg::LagW-1:0];
        sdtl_pkg::REG_DEAD:  dead_q  <= pwdata[sdtl_pkg::DeadW-1:0];
        sdtl_pkg::REG_STEER: steer_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // datapath
  always_comb begin
    uw = busy_q ? sdtl_pkg::ucode(step_q) : sdtl_pkg::ucode(sdtl_pkg::StepFinish + 4'd1);
    unique case (uw.mul_src)
      sdtl_pkg::MUL_C3: mul_a = {c3_q[31], c3_q};
      sdtl_pkg::MUL_H0: mul_a = {uw.top_signed & h_q[31], h_q[31:0]};
      sdtl_pkg::MUL_H1: mul_a = {uw.top_signed & h_q[63], h_q[63:32]};
      sdtl_pkg::MUL_H2: mul_a = {uw.top_signed & h_q[95], h_q[95:64]};
      default:          mul_a = '0;
    endcase
    mul_full = mul_a * x_q;
    unique case (uw.shift)
      2'd0:    prod_sh = {{63{prod_q[64]}}, prod_q};
      2'd1:    prod_sh = {{31{prod_q[64]}}, prod_q, 32'b0};
      default: prod_sh = {prod_q[63:0], 64'b0};
    endcase
    add_res = acc_q + prod_sh;
    cv = {c0_q[31], c0_q} - {sv_q[31], sv_q};
    unique case (uw.ld_sel)
      sdtl_pkg::LD_C1: ld_val = {{48{c1_q[31]}}, c1_q, 48'b0};
      sdtl_pkg::LD_CV: ld_val = {{23{cv[32]}}, cv, 72'b0};
      default:         ld_val = {{72{c2_q[31]}}, c2_q, 24'b0};
    endcase
    ok = c3_q[31] ? ~add_res[127] : (add_res[127] | (add_res == '0));
    bit_mask  = 32'd1 << bit_q;
    bit_dec   = bit_q - 5'd1;
    next_mask = 32'd1 << bit_dec;
    r_new = ok ? (r_q | bit_mask) : r_q;

    cur_sel = usem_q ? meas_q : (pv_q ? last_q : tgt_q);
    delayed = filled_q ? (byp_q ? tgt_q : signed'(rd_data)) : cur_q;
    diff    = {delayed[31], delayed} - {cur_q[31], cur_q};
    lag_eff = (lag_q > sdtl_pkg::LagOne) ? sdtl_pkg::LagOne : lag_q;
    lag_s   = {1'b0, lag_eff};
    lag_full = diff * lag_s;
    quot = lagp_q[58:24];
    sum  = {quot[34], quot} + {{4{cur_q[31]}}, cur_q};
    if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
      next_val = sum[31:0];
    end else begin
      next_val = sum[35] ? sdtl_pkg::ValMin : sdtl_pkg::ValMax;
    end
    fin_fire = busy_q & (uw.act == sdtl_pkg::ACT_FINISH) & (~out_valid_q | ~out_stall_i);

    dl_ctrl.push   = busy_q & (uw.act == sdtl_pkg::ACT_FETCH);
    dl_ctrl.shrink = cfg_we & (idx == sdtl_pkg::REG_DEAD);
  end

  sdtl_delay_line #(.DEPTH(DELAY_DEPTH)) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (dl_ctrl),
    .wr_data_i (tgt_q),
    .eff_i     (eff_dead(dead_q)),
    .eff_new_i (eff_dead(pwdata[sdtl_pkg::DeadW-1:0])),
    .rd_data_o (rd_data),
    .stat_o    (dl_stat)
  );

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= sdtl_pkg::StepLoop;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (in_fire) begin
        busy_q <= 1'b1;
        if (!steer_q) begin
          step_q <= sdtl_pkg::StepFinish;
        end else if (c3_q == '0) begin
          step_q <= sdtl_pkg::StepFetch;
        end else begin
          step_q <= sdtl_pkg::StepLoop;
        end
      end else if (busy_q) begin
        unique case (uw.act)
          sdtl_pkg::ACT_DECIDE:
            step_q <= (bit_q == '0) ? sdtl_pkg::StepFetch : sdtl_pkg::StepLoop;
          sdtl_pkg::ACT_FINISH: begin
            if (fin_fire) begin
              busy_q      <= 1'b0;
              out_valid_q <= 1'b1;
              if (!pass_q) pv_q <= 1'b1;
            end
          end
          default: step_q <= step_q + 4'd1;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sv_q   <= in_data_i.set_value;
      meas_q <= in_data_i.measured_angle;
      usem_q <= in_data_i.use_measured;
      pass_q <= ~steer_q;
      tgt_q  <= sdtl_pkg::ValMax;
      r_q    <= '0;
      bit_q  <= 5'd31;
      x_q    <= '0;
    end
    if (uw.mul_src != sdtl_pkg::MUL_NONE) prod_q <= mul_full;
    unique case (uw.acc_op)
      sdtl_pkg::ACC_LOAD: acc_q <= ld_val;
      sdtl_pkg::ACC_ADD:  acc_q <= add_res;
      sdtl_pkg::ACC_SAVE: begin
        h_q   <= add_res;
        acc_q <= ld_val;
      end
      default: ;
    endcase
    if (busy_q) begin
      unique case (uw.act)
        sdtl_pkg::ACT_DECIDE: begin
          r_q   <= r_new;
          bit_q <= bit_dec;
          x_q   <= signed'((r_new | next_mask) ^ sdtl_pkg::ValMin);
          tgt_q <= signed'(r_new ^ sdtl_pkg::ValMin);
        end
        sdtl_pkg::ACT_FETCH: begin
          cur_q    <= cur_sel;
          filled_q <= dl_stat.filled;
          byp_q    <= dl_stat.bypass;
        end
        sdtl_pkg::ACT_LAG: lagp_q <= lag_full;
        sdtl_pkg::ACT_FINISH: begin
          if (fin_fire) begin
            if (pass_q) begin
              out_q.predicted_angle <= sv_q;
              out_q.line_filled     <= 1'b0;
            end else begin
              out_q.predicted_angle <= next_val;
              out_q.line_filled     <= filled_q;
              last_q                <= next_val;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
